>>> hdl/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, codes and constants of the byte-serial SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

	// Request codes carried in req_type. The fourth code is unused.
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_DATA   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	// Source of the byte shifted into the message window.
	localparam logic [1:0] BSEL_MSG  = 2'd0;
	localparam logic [1:0] BSEL_PAD  = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] IV_H0 = 32'h67452301;
	localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
	localparam logic [31:0] IV_H2 = 32'h98BADCFE;
	localparam logic [31:0] IV_H3 = 32'h10325476;
	localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [6:0] ROUND_LAST  = 7'd79;
	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [5:0] FILL_LENPOS = 6'd56;
	localparam logic [2:0] WORD_LAST   = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] msg_byte;
	} sha1h_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
		logic        hash_error;
	} sha1h_dig_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       init;
		logic       shift;
		logic [1:0] bsel;
		logic       count_len;
		logic       set_corrupt;
		logic       set_done;
		logic       round;
		logic [6:0] round_idx;
		logic       fold;
		logic       load_out;
		logic       out_err;
		logic [2:0] word_idx;
	} sha1h_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill;
		logic       done;
		logic       corrupt;
	} sha1h_sts_t;

endpackage

>>> hdl/sha1h_stream_if.sv
// ----------------------------------------------------------------------------
// sha1h_stream_if
// Valid/ready channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
interface sha1h_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/sha1h_dp.sv
// ----------------------------------------------------------------------------
// sha1h_dp
// SHA-1 datapath: 512-bit message window that doubles as the message
// schedule, bit counter, hash words, one-round-per-cycle compression and
// the result register.
// ----------------------------------------------------------------------------
module sha1h_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1h_pkg::sha1h_cmd_t cmd,
	input  logic [7:0]            msg_byte,
	output sha1h_pkg::sha1h_sts_t sts,
	output sha1h_pkg::sha1h_dig_t dig_data
);
	import sha1h_pkg::*;

	logic [511:0] win_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h0_q, h1_q, h2_q, h3_q, h4_q;
	logic [63:0]  len_q;
	logic [5:0]   fill_q;
	logic         done_q;
	logic         corrupt_q;
	sha1h_dig_t   dig_q;

	logic [7:0]   byte_in;
	logic [7:0]   len_byte;
	logic [31:0]  w0, w2, w8, w13;
	logic [31:0]  w_new;
	logic [31:0]  f_val;
	logic [31:0]  k_val;
	logic [31:0]  t_val;
	logic [31:0]  hsel;
	logic         len_wrap;

	// Length bytes go out most significant first; fill 56..63 picks len_q byte 7..0.
	assign len_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		unique case (cmd.bsel)
			BSEL_MSG:  byte_in = msg_byte;
			BSEL_PAD:  byte_in = PAD_BYTE;
			BSEL_ZERO: byte_in = 8'h00;
			BSEL_LEN:  byte_in = len_byte;
			default:   byte_in = 8'h00;
		endcase
	end

	// The window holds w[t] .. w[t+15], w[t] in the top word.
	assign w0    = win_q[511:480];
	assign w2    = win_q[447:416];
	assign w8    = win_q[255:224];
	assign w13   = win_q[95:64];
	assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
		w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

	always_comb begin
		if (cmd.round_idx < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (cmd.round_idx < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (cmd.round_idx < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w0 + k_val;

	always_comb begin
		unique case (cmd.word_idx)
			3'd0:    hsel = h0_q;
			3'd1:    hsel = h1_q;
			3'd2:    hsel = h2_q;
			3'd3:    hsel = h3_q;
			default: hsel = h4_q;
		endcase
	end

	// Adding 8 wraps the 64-bit count to zero exactly when bits 63..3 are all set.
	assign len_wrap = &len_q[63:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			len_q     <= '0;
			done_q    <= 1'b0;
			corrupt_q <= 1'b0;
			h0_q      <= IV_H0;
			h1_q      <= IV_H1;
			h2_q      <= IV_H2;
			h3_q      <= IV_H3;
			h4_q      <= IV_H4;
		end else begin
			if (cmd.init) begin
				fill_q    <= '0;
				len_q     <= '0;
				done_q    <= 1'b0;
				corrupt_q <= 1'b0;
				h0_q      <= IV_H0;
				h1_q      <= IV_H1;
				h2_q      <= IV_H2;
				h3_q      <= IV_H3;
				h4_q      <= IV_H4;
			end else begin
				if (cmd.shift) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.count_len) begin
					len_q <= len_q + 64'd8;
				end
				if (cmd.set_corrupt || (cmd.count_len && len_wrap)) begin
					corrupt_q <= 1'b1;
				end
				if (cmd.set_done) begin
					done_q <= 1'b1;
				end
				if (cmd.fold) begin
					h0_q <= h0_q + a_q;
					h1_q <= h1_q + b_q;
					h2_q <= h2_q + c_q;
					h3_q <= h3_q + d_q;
					h4_q <= h4_q + e_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			win_q <= {win_q[503:0], byte_in};
			// The last byte of a block also seeds the working variables.
			if (fill_q == FILL_LAST) begin
				a_q <= h0_q;
				b_q <= h1_q;
				c_q <= h2_q;
				d_q <= h3_q;
				e_q <= h4_q;
			end
		end else if (cmd.round) begin
			win_q <= {win_q[479:0], w_new};
			a_q   <= t_val;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
		end
		if (cmd.load_out) begin
			if (cmd.out_err) begin
				dig_q.digest_word <= '0;
				dig_q.word_number <= '0;
				dig_q.last_word   <= 1'b1;
				dig_q.hash_error  <= 1'b1;
			end else begin
				dig_q.digest_word <= hsel;
				dig_q.word_number <= cmd.word_idx;
				dig_q.last_word   <= (cmd.word_idx == WORD_LAST);
				dig_q.hash_error  <= 1'b0;
			end
		end
	end

	assign sts.fill    = fill_q;
	assign sts.done    = done_q;
	assign sts.corrupt = corrupt_q;
	assign dig_data    = dig_q;

endmodule

>>> hdl/sha1h_ctrl.sv
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Controller: request decode, padding sequence, round counter and digest
// emission with the result valid flag.
// ----------------------------------------------------------------------------
module sha1h_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [1:0]            req_type,
	output logic                  req_ready,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	input  sha1h_pkg::sha1h_sts_t sts,
	output sha1h_pkg::sha1h_cmd_t cmd
);
	import sha1h_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_COMP   = 3'd1;
	localparam logic [2:0] S_FOLD   = 3'd2;
	localparam logic [2:0] S_PAD80  = 3'd3;
	localparam logic [2:0] S_PADZ   = 3'd4;
	localparam logic [2:0] S_PADLEN = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0] state_q, state_nx;
	logic [6:0] rnd_q;
	logic [2:0] wc_q;
	logic       pad_q;
	logic       lenblk_q;
	logic       err_q;
	logic       out_vld_q;
	logic       acc;
	logic       out_space;
	logic       fill_last;

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_space = !out_vld_q || dig_ready;
	assign fill_last = (sts.fill == FILL_LAST);
	assign dig_valid = out_vld_q;

	always_comb begin
		cmd           = '0;
		cmd.round_idx = rnd_q;
		cmd.word_idx  = wc_q;
		cmd.out_err   = err_q;
		state_nx      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req_type)
						REQ_START: cmd.init = 1'b1;
						REQ_DATA: begin
							if (sts.done || sts.corrupt) begin
								cmd.set_corrupt = 1'b1;
							end else begin
								cmd.shift     = 1'b1;
								cmd.bsel      = BSEL_MSG;
								cmd.count_len = 1'b1;
								if (fill_last) begin
									state_nx = S_COMP;
								end
							end
						end
						REQ_FINISH: begin
							if (sts.corrupt || sts.done) begin
								state_nx = S_EMIT;
							end else begin
								state_nx = S_PAD80;
							end
						end
						default: ;
					endcase
				end
			end
			S_PAD80: begin
				cmd.shift = 1'b1;
				cmd.bsel  = BSEL_PAD;
				state_nx  = fill_last ? S_COMP : S_PADZ;
			end
			S_PADZ: begin
				if (sts.fill == FILL_LENPOS) begin
					state_nx = S_PADLEN;
				end else begin
					cmd.shift = 1'b1;
					cmd.bsel  = BSEL_ZERO;
					if (fill_last) begin
						state_nx = S_COMP;
					end
				end
			end
			S_PADLEN: begin
				cmd.shift = 1'b1;
				cmd.bsel  = BSEL_LEN;
				if (fill_last) begin
					state_nx = S_COMP;
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				if (rnd_q == ROUND_LAST) begin
					state_nx = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (!pad_q) begin
					state_nx = S_IDLE;
				end else if (lenblk_q) begin
					cmd.set_done = 1'b1;
					state_nx     = S_EMIT;
				end else begin
					state_nx = S_PADZ;
				end
			end
			S_EMIT: begin
				if (out_space) begin
					cmd.load_out = 1'b1;
					if (err_q || wc_q == WORD_LAST) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rnd_q     <= '0;
			wc_q      <= '0;
			pad_q     <= 1'b0;
			lenblk_q  <= 1'b0;
			err_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (acc) begin
				pad_q    <= (req_type == REQ_FINISH) && !sts.corrupt && !sts.done;
				err_q    <= (req_type == REQ_FINISH) && sts.corrupt;
				lenblk_q <= 1'b0;
				wc_q     <= '0;
			end
			if (state_q == S_PADLEN && fill_last) begin
				lenblk_q <= 1'b1;
			end
			if (state_q == S_COMP) begin
				rnd_q <= (rnd_q == ROUND_LAST) ? 7'd0 : rnd_q + 7'd1;
			end
			if (cmd.load_out) begin
				wc_q <= (wc_q == WORD_LAST) ? 3'd0 : wc_q + 3'd1;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (dig_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_round_only_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COMP) |-> (rnd_q == 7'd0))
		else $error("round counter active outside compression");

	a_word_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wc_q <= WORD_LAST))
		else $error("digest word counter out of range");

	a_comp_on_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COMP && state_nx == S_COMP) |-> fill_last)
		else $error("compression started on a partial block");

	a_len_block_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOLD && pad_q && lenblk_q) |=> (state_q == S_EMIT && sts.done))
		else $error("final padded block did not lead to digest output");

endmodule

>>> hdl/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// Byte-serial SHA-1 engine with a request channel and a digest channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per beat: start (load initial hash, clear
//   length and flags), data (one message byte) or finish (pad and emit).
//   dig_ch carries one digest word per beat, word 0 first, last_word set on
//   word 4; a corrupt message gives a single beat with hash_error set.
//   The data byte that completes a 64-byte block starts the compression:
//   80 rounds at one round per cycle and one fold; the working words load
//   with the byte itself. A first finish shifts the padding and the length
//   in at one byte per cycle, with a pause in which no byte shifts at the
//   length field (S_PADZ hands over to S_PADLEN), compresses one or two
//   blocks the same way, then loads five words at one per cycle while
//   dig_ch takes them; a repeated finish goes straight to loading the words.
//   Requests are taken only while the controller is idle; the result
//   register lets the next request in while the last word waits.
//   When dig_ch stalls, emission pauses with the word held in the register.
//   Reset loads the standard initial hash words and clears length and flags.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
	input logic            clk,
	input logic            arst_n,
	sha1h_stream_if.sink   req_ch,
	sha1h_stream_if.source dig_ch
);
	import sha1h_pkg::*;

	sha1h_cmd_t cmd;
	sha1h_sts_t sts;
	sha1h_req_t req_data;
	sha1h_dig_t dig_data;
	logic       req_ready;
	logic       dig_valid;

	assign req_data     = req_ch.data;
	assign req_ch.ready = req_ready;
	assign dig_ch.valid = dig_valid;
	assign dig_ch.data  = dig_data;

	sha1h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_type  (req_data.req_type),
		.req_ready (req_ready),
		.dig_valid (dig_valid),
		.dig_ready (dig_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1h_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.msg_byte (req_data.msg_byte),
		.sts      (sts),
		.dig_data (dig_data)
	);

endmodule

>>> verif/sha1h_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_digest_checker
// Watches the request and digest channels of the SHA-1 hasher. It keeps its
// own copy of the message state, computes the digest words that each
// accepted request must produce, and compares every digest beat with the
// oldest expected word.
// ----------------------------------------------------------------------------
module sha1h_digest_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  sha1h_pkg::sha1h_req_t req_data,
	input  logic                  dig_valid,
	input  logic                  dig_ready,
	input  sha1h_pkg::sha1h_dig_t dig_data,
	output int                    mismatch_count,
	output int                    pending_words
);
	import sha1h_pkg::*;

	logic [7:0]  blk_bytes [64];
	logic [6:0]  blk_fill;
	logic [63:0] msg_bits;
	logic [31:0] chain [5];
	logic        msg_done;
	logic        msg_corrupt;
	sha1h_dig_t  expected_words [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic restart_message();
		for (int i = 0; i < 64; i++) begin
			blk_bytes[i] = 8'h00;
		end
		blk_fill = '0;
		msg_bits = '0;
		chain[0] = IV_H0;
		chain[1] = IV_H1;
		chain[2] = IV_H2;
		chain[3] = IV_H3;
		chain[4] = IV_H4;
		msg_done = 1'b0;
		msg_corrupt = 1'b0;
	endtask

	task automatic compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rol(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
		chain[4] = chain[4] + e;
		blk_fill = '0;
	endtask

	// A pad byte that lands in the length field (byte 56 or later) pushes the
	// length into a second block.
	task automatic pad_message();
		int pos;
		pos = int'(blk_fill[5:0]);
		blk_bytes[pos] = PAD_BYTE;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk_bytes[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk_bytes[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++) begin
			blk_bytes[56+i] = msg_bits[63-8*i -: 8];
		end
		compress_block();
	endtask

	task automatic apply_request(input sha1h_req_t req);
		sha1h_dig_t word;
		case (req.req_type)
			REQ_START: begin
				restart_message();
			end
			REQ_DATA: begin
				if (msg_done || msg_corrupt) begin
					msg_corrupt = 1'b1;
				end else begin
					blk_bytes[blk_fill[5:0]] = req.msg_byte;
					blk_fill = blk_fill + 7'd1;
					msg_bits = msg_bits + 64'd8;
					if (msg_bits == 64'd0)
						msg_corrupt = 1'b1;
					if (blk_fill >= 7'd64)
						compress_block();
				end
			end
			REQ_FINISH: begin
				if (msg_corrupt) begin
					word = '{digest_word: 32'h0, word_number: 3'd0, last_word: 1'b1,
						hash_error: 1'b1};
					expected_words.push_back(word);
				end else begin
					if (!msg_done) begin
						pad_message();
						msg_done = 1'b1;
					end
					for (int i = 0; i < 5; i++) begin
						word.digest_word = chain[i];
						word.word_number = 3'(i);
						word.last_word = (3'(i) == WORD_LAST);
						word.hash_error = 1'b0;
						expected_words.push_back(word);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_beat(input sha1h_dig_t got);
		sha1h_dig_t want;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected digest beat word=%h num=%0d last=%0b err=%0b",
				$time, got.digest_word, got.word_number, got.last_word, got.hash_error);
			mismatch_count++;
		end else begin
			want = expected_words.pop_front();
			if (got.digest_word !== want.digest_word) begin
				$display("%0t: digest_word expected %h actual %h",
					$time, want.digest_word, got.digest_word);
				mismatch_count++;
			end
			if (got.word_number !== want.word_number) begin
				$display("%0t: word_number expected %0d actual %0d",
					$time, want.word_number, got.word_number);
				mismatch_count++;
			end
			if (got.last_word !== want.last_word) begin
				$display("%0t: last_word expected %0b actual %0b",
					$time, want.last_word, got.last_word);
				mismatch_count++;
			end
			if (got.hash_error !== want.hash_error) begin
				$display("%0t: hash_error expected %0b actual %0b",
					$time, want.hash_error, got.hash_error);
				mismatch_count++;
			end
		end
	endtask

	initial begin
		mismatch_count = 0;
		pending_words = 0;
	end

	// A digest beat at this edge always belongs to an earlier request, so it
	// is checked before the request taken at the same edge is applied.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			expected_words.delete();
		end else begin
			if (dig_valid && dig_ready)
				check_beat(dig_data);
			if (req_valid && req_ready)
				apply_request(req_data);
		end
		pending_words = expected_words.size();
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the byte-serial SHA-1 hasher. It sends a directed sequence of
// start, data, finish and unused requests, then random messages of short and
// block-boundary lengths mixed with broken sequences and noise, with random
// gaps on both channels. A separate checker predicts and compares the digest.
// ----------------------------------------------------------------------------
module tb_top;
	import sha1h_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	int          mismatch_count;
	int          pending_words;
	int unsigned counted_reqs;
	logic        send_burst;
	logic        recv_burst;
	logic        drained_once;

	sha1h_stream_if #(.payload_t(sha1h_req_t)) req_if ();
	sha1h_stream_if #(.payload_t(sha1h_dig_t)) dig_if ();

	sha1_byte_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_if),
		.dig_ch (dig_if)
	);

	sha1h_digest_checker u_digest_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_if.valid),
		.req_ready      (req_if.ready),
		.req_data       (req_if.data),
		.dig_valid      (dig_if.valid),
		.dig_ready      (dig_if.ready),
		.dig_data       (dig_if.data),
		.mismatch_count (mismatch_count),
		.pending_words  (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Valid stays high across back-to-back beats; it is lowered only when a
	// gap follows, so it never gets two assignments in one step.
	task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 19) == 0)
			send_burst = ~send_burst;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= '{req_type: kind, msg_byte: value};
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (kind != REQ_UNUSED)
			counted_reqs++;
	endtask

	task automatic send_bytes(input int count);
		for (int i = 0; i < count; i++) begin
			send_req(REQ_DATA, 8'($urandom));
		end
	endtask

	function automatic int draw_length();
		int boundary_lens [6];
		boundary_lens = '{55, 56, 57, 63, 64, 65};
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 12);
		return boundary_lens[$urandom_range(0, 5)];
	endfunction

	initial begin : stimulus
		int unsigned base;
		int pick;
		int len;
		req_if.valid = 1'b0;
		req_if.data = '0;
		arst_n = 1'b0;
		counted_reqs = 0;
		send_burst = 1'b0;
		drained_once = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message straight from reset, then a repeated finish.
		send_req(REQ_FINISH, 8'h00);
		send_req(REQ_FINISH, 8'hFF);
		// Data after finish marks the message corrupt; finish reports it twice.
		send_req(REQ_DATA, 8'hA5);
		send_req(REQ_FINISH, 8'h00);
		send_req(REQ_FINISH, 8'h00);
		send_req(REQ_UNUSED, 8'hFF);
		send_req(REQ_START, 8'hFF);
		send_req(REQ_DATA, 8'h00);
		send_req(REQ_DATA, 8'hFF);
		send_req(REQ_UNUSED, 8'h5A);
		send_req(REQ_DATA, 8'h61);
		send_req(REQ_FINISH, 8'hFF);
		send_req(REQ_START, 8'h00);
		send_req(REQ_DATA, 8'h61);
		send_req(REQ_DATA, 8'h62);
		send_req(REQ_DATA, 8'h63);
		send_req(REQ_FINISH, 8'h00);
		send_req(REQ_START, 8'h00);
		send_req(REQ_FINISH, 8'h00);

		base = counted_reqs;
		while (counted_reqs - base < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_req(REQ_START, 8'($urandom));
				send_bytes(draw_length());
				send_req(REQ_FINISH, 8'($urandom));
				if ($urandom_range(0, 3) == 0)
					send_req(REQ_FINISH, 8'($urandom));
			end else if (pick == 7) begin
				send_req(REQ_START, 8'($urandom));
				send_bytes($urandom_range(0, 8));
				send_req(REQ_FINISH, 8'($urandom));
				send_bytes($urandom_range(1, 3));
				send_req(REQ_FINISH, 8'($urandom));
			end else if (pick == 8) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_req(2'($urandom_range(0, 3)), 8'($urandom));
				end
			end else begin
				// Restart in the middle of a message, with unused codes mixed in.
				send_req(REQ_START, 8'($urandom));
				send_bytes($urandom_range(1, 20));
				send_req(REQ_START, 8'($urandom));
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 3) == 0)
						send_req(REQ_UNUSED, 8'($urandom));
					send_req(REQ_DATA, 8'($urandom));
				end
				send_req(REQ_FINISH, 8'($urandom));
			end
			if (!drained_once && counted_reqs - base >= RANDOM_ITEMS / 2) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
				while (pending_words != 0) @(posedge clk);
				drained_once = 1'b1;
			end
		end

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_words == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin : digest_sink
		int stall;
		dig_if.ready = 1'b0;
		recv_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_burst ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 19) == 0)
				recv_burst = ~recv_burst;
			if (stall > 0) begin
				dig_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dig_if.ready <= 1'b1;
			@(posedge clk);
			while (!dig_if.valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: errors");
		$finish;
	end

endmodule

>>> files.f
hdl/sha1h_pkg.sv
hdl/sha1h_stream_if.sv
hdl/sha1h_dp.sv
hdl/sha1h_ctrl.sv
hdl/sha1_byte_stream_hasher.sv
verif/sha1h_digest_checker.sv
verif/tb_top.sv
